// ===== rtl/core/gaussian_pair_force_defines.svh =====
// Assertion macros shared by the checker of the Gaussian pair force block.
`ifndef GAUSSIAN_PAIR_FORCE_DEFINES_SVH
`define GAUSSIAN_PAIR_FORCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpf assertion failed");

// Next-cycle implication, checked outside reset.
`define GPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpf assertion failed");

`endif

// ===== rtl/core/gpf_pkg.sv =====
// Types, constants and helper functions of the Gaussian pair force block.
package gpf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int RX_W       = FRAC_BITS + 5;
  localparam int T_W        = FRAC_BITS + 8;
  localparam int A_W        = 36;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] LN2_Q30   = 32'd744261118;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [63:0] RX_LIMIT  = 64'd16 << FRAC_BITS;
  localparam logic [63:0] T_LIMIT   = 64'd64 << FRAC_BITS;
  localparam logic [32:0] W_LIMIT   = {33{1'b1}};
  localparam logic [3:0]  K_START   = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUT_SQ,
    REG_CENTER,
    REG_INV_SIGMA,
    REG_PREFACTOR,
    REG_OFFSET,
    REG_ENERGY_EN
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        cut_sq;
    logic [30:0]        center_distance;
    logic [30:0]        inv_sigma;
    logic signed [31:0] prefactor;
    logic signed [31:0] energy_offset;
    logic               energy_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic               last_neighbor;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pair_fx;
    logic signed [31:0] pair_fy;
    logic signed [31:0] pair_fz;
    logic signed [31:0] pair_energy;
    logic               in_range;
    logic signed [47:0] sum_fx;
    logic signed [47:0] sum_fy;
    logic signed [47:0] sum_fz;
    logic               sum_final;
  } out_item_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_SQX, OP_SQY, OP_SQZ, OP_SQADD, OP_CMP, OP_SQRT,
    OP_DIFF, OP_RXMUL, OP_RX, OP_TMUL, OP_T, OP_YMUL, OP_Y, OP_ZMUL, OP_Z,
    OP_EMUL1, OP_EMUL2, OP_EUPD, OP_G, OP_UMUL, OP_U, OP_AMUL, OP_A,
    OP_WMUL1, OP_WMUL2, OP_W, OP_FXMUL, OP_FYMUL, OP_FZMUL, OP_FZ,
    OP_DIVINIT, OP_DIV, OP_FIN, OP_ACC
  } dp_op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_SQADD, S_CMP, S_SQRT, S_DIFF, S_RXMUL,
    S_RX, S_TMUL, S_T, S_YMUL, S_Y, S_ZMUL, S_Z, S_EMUL1, S_EMUL2, S_EUPD,
    S_G, S_UMUL, S_U, S_AMUL, S_A, S_WMUL1, S_WMUL2, S_W, S_FXMUL, S_FYMUL,
    S_FZMUL, S_FZ, S_DIVINIT, S_DIV, S_FIN, S_ACC
  } gpf_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic r_zero;
  } dp_stat_t;

  // floor(2^32 / k), with k = 1 held just below 2^32; one correction step
  // after the multiply recovers the exact quotient.
  function automatic logic [31:0] k_recip(input logic [3:0] k);
    logic [31:0] v;
    case (k)
      4'd2:    v = 32'h8000_0000;
      4'd3:    v = 32'h5555_5555;
      4'd4:    v = 32'h4000_0000;
      4'd5:    v = 32'h3333_3333;
      4'd6:    v = 32'h2AAA_AAAA;
      4'd7:    v = 32'h2492_4924;
      4'd8:    v = 32'h2000_0000;
      4'd9:    v = 32'h1C71_C71C;
      default: v = 32'hFFFF_FFFF;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/gpf_ctrl.sv =====
// Sequencer of the Gaussian pair force block: steps the datapath per item.
module gpf_ctrl import gpf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  gpf_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= K_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = OP_NOP;
    cmd.k         = k_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SQX;
        end
      end
      S_SQX:   begin cmd.op = OP_SQX;   state_nxt = S_SQY;   end
      S_SQY:   begin cmd.op = OP_SQY;   state_nxt = S_SQZ;   end
      S_SQZ:   begin cmd.op = OP_SQZ;   state_nxt = S_SQADD; end
      S_SQADD: begin cmd.op = OP_SQADD; state_nxt = S_CMP;   end
      S_CMP: begin
        cmd.op    = OP_CMP;
        cnt_nxt   = '0;
        // An out-of-range item still reports its running sums.
        state_nxt = stat.hit ? S_SQRT : S_ACC;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_DIFF;
      end
      S_DIFF:  begin cmd.op = OP_DIFF;  state_nxt = S_RXMUL; end
      S_RXMUL: begin cmd.op = OP_RXMUL; state_nxt = S_RX;    end
      S_RX:    begin cmd.op = OP_RX;    state_nxt = S_TMUL;  end
      S_TMUL:  begin cmd.op = OP_TMUL;  state_nxt = S_T;     end
      S_T:     begin cmd.op = OP_T;     state_nxt = S_YMUL;  end
      S_YMUL:  begin cmd.op = OP_YMUL;  state_nxt = S_Y;     end
      S_Y:     begin cmd.op = OP_Y;     state_nxt = S_ZMUL;  end
      S_ZMUL:  begin cmd.op = OP_ZMUL;  state_nxt = S_Z;     end
      S_Z: begin
        cmd.op    = OP_Z;
        k_nxt     = K_START;
        state_nxt = S_EMUL1;
      end
      S_EMUL1: begin cmd.op = OP_EMUL1; state_nxt = S_EMUL2; end
      S_EMUL2: begin cmd.op = OP_EMUL2; state_nxt = S_EUPD;  end
      S_EUPD: begin
        cmd.op = OP_EUPD;
        if (k_r == 4'd1) begin
          state_nxt = S_G;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_EMUL1;
        end
      end
      S_G:     begin cmd.op = OP_G;     state_nxt = S_UMUL;  end
      S_UMUL:  begin cmd.op = OP_UMUL;  state_nxt = S_U;     end
      S_U:     begin cmd.op = OP_U;     state_nxt = S_AMUL;  end
      S_AMUL:  begin cmd.op = OP_AMUL;  state_nxt = S_A;     end
      S_A:     begin cmd.op = OP_A;     state_nxt = S_WMUL1; end
      S_WMUL1: begin cmd.op = OP_WMUL1; state_nxt = S_WMUL2; end
      S_WMUL2: begin cmd.op = OP_WMUL2; state_nxt = S_W;     end
      S_W:     begin cmd.op = OP_W;     state_nxt = S_FXMUL; end
      S_FXMUL: begin cmd.op = OP_FXMUL; state_nxt = S_FYMUL; end
      S_FYMUL: begin cmd.op = OP_FYMUL; state_nxt = S_FZMUL; end
      S_FZMUL: begin cmd.op = OP_FZMUL; state_nxt = S_FZ;    end
      S_FZ:    begin cmd.op = OP_FZ;    state_nxt = S_DIVINIT; end
      S_DIVINIT: begin
        cmd.op    = OP_DIVINIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin cmd.op = OP_FIN; state_nxt = S_ACC; end
      S_ACC: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_ACC;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/gpf_datapath.sv =====
// Datapath of the Gaussian pair force block: shared multiplier, square root,
// exponential series, three-lane divider and force accumulators.
module gpf_datapath import gpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  logic [31:0]        mag_r [3];
  logic               dneg_r [3];
  logic               last_r;
  logic [63:0]        prod_r, rsq_r;
  logic               hit_r;
  logic [63:0]        sv_r, sres_r, sbit_r;
  logic [31:0]        r_r, diff_r;
  logic               rneg_r;
  logic [RX_W-1:0]    rx_r;
  logic [T_W-1:0]     t_r;
  logic               gzero_r;
  logic [7:0]         n_r;
  logic [29:0]        x_r, z_r, p_r;
  logic [30:0]        q_r, g_r;
  logic [31:0]        umag_r;
  logic [A_W-1:0]     a_r;
  logic [63:0]        wlo_r;
  logic [32:0]        w_r;
  logic [63:0]        num_r [3];
  logic [31:0]        rem_r [3], lo_r [3], quo_r [3];
  logic               ovf_r [3];
  logic signed [31:0] f_r [3];
  logic signed [31:0] energy_r;
  logic signed [47:0] acc_r [3];
  out_item_t          out_r;

  logic [31:0] ma, mb, pf_mag, recip;
  logic [63:0] cut_wide, cand, rxs, tt, yy;
  logic [29:0] qest, rem_k;
  logic [33:0] qk;
  logic [30:0] qd;
  logic [67:0] wsum, ws;
  logic signed [33:0] u_s, e_s;
  logic        fneg;

  assign pf_mag   = cfg.prefactor[31] ? (~cfg.prefactor + 32'd1) : cfg.prefactor;
  assign recip    = k_recip(cmd.k);
  assign cut_wide = {32'd0, cfg.cut_sq} << FRAC_BITS;
  assign stat.hit    = rsq_r < cut_wide;
  assign stat.r_zero = (r_r == 32'd0);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_SQX:   begin ma = mag_r[0]; mb = mag_r[0]; end
      OP_SQY:   begin ma = mag_r[1]; mb = mag_r[1]; end
      OP_SQZ:   begin ma = mag_r[2]; mb = mag_r[2]; end
      OP_RXMUL: begin ma = diff_r; mb = {1'b0, cfg.inv_sigma}; end
      OP_TMUL:  begin ma = 32'(rx_r); mb = 32'(rx_r); end
      OP_YMUL:  begin ma = 32'(t_r); mb = LOG2E_Q30; end
      OP_ZMUL:  begin ma = {2'b0, x_r}; mb = LN2_Q30; end
      OP_EMUL1: begin ma = {2'b0, z_r}; mb = {1'b0, q_r}; end
      OP_EMUL2: begin ma = {2'b0, prod_r[59:30]}; mb = recip; end
      OP_UMUL:  begin ma = pf_mag; mb = {1'b0, g_r}; end
      OP_AMUL:  begin ma = 32'(rx_r); mb = umag_r; end
      OP_WMUL1: begin ma = a_r[31:0]; mb = {1'b0, cfg.inv_sigma}; end
      OP_WMUL2: begin ma = 32'(a_r[A_W-1:32]); mb = {1'b0, cfg.inv_sigma}; end
      OP_FXMUL: begin ma = mag_r[0]; mb = w_r[31:0]; end
      OP_FYMUL: begin ma = mag_r[1]; mb = w_r[31:0]; end
      OP_FZMUL: begin ma = mag_r[2]; mb = w_r[31:0]; end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    cand  = sres_r + sbit_r;
    rxs   = prod_r >> FRAC_BITS;
    tt    = prod_r >> (FRAC_BITS + 1);
    yy    = prod_r >> 30;
    qest  = prod_r[61:32];
    qk    = qest * cmd.k;
    rem_k = p_r - qk[29:0];
    qd    = (rem_k >= 30'(cmd.k)) ? 31'(qest) + 31'd1 : 31'(qest);
    wsum  = {4'd0, wlo_r} + {prod_r[35:0], 32'd0};
    ws    = wsum >> FRAC_BITS;
    u_s   = cfg.prefactor[31] ? -$signed({2'b0, umag_r}) : $signed({2'b0, umag_r});
    e_s   = u_s - 34'(cfg.energy_offset);
    fneg  = rneg_r != cfg.prefactor[31];
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (cmd.op)
      OP_LOAD: begin
        mag_r[0]  <= in_data.disp_x[31] ? (~in_data.disp_x + 32'd1) : in_data.disp_x;
        mag_r[1]  <= in_data.disp_y[31] ? (~in_data.disp_y + 32'd1) : in_data.disp_y;
        mag_r[2]  <= in_data.disp_z[31] ? (~in_data.disp_z + 32'd1) : in_data.disp_z;
        dneg_r[0] <= in_data.disp_x[31];
        dneg_r[1] <= in_data.disp_y[31];
        dneg_r[2] <= in_data.disp_z[31];
        last_r    <= in_data.last_neighbor;
        for (int i = 0; i < 3; i++) f_r[i] <= '0;
        energy_r  <= '0;
      end
      OP_SQY:   rsq_r <= prod_r;
      OP_SQZ:   rsq_r <= rsq_r + prod_r;
      OP_SQADD: rsq_r <= rsq_r + prod_r;
      OP_CMP: begin
        hit_r  <= stat.hit;
        sv_r   <= rsq_r;
        sres_r <= '0;
        sbit_r <= 64'd1 << 62;
      end
      OP_SQRT: begin
        if (sv_r >= cand) begin
          sv_r   <= sv_r - cand;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      OP_DIFF: begin
        r_r    <= sres_r[31:0];
        rneg_r <= sres_r[31:0] < {1'b0, cfg.center_distance};
        diff_r <= (sres_r[31:0] < {1'b0, cfg.center_distance}) ?
                  {1'b0, cfg.center_distance} - sres_r[31:0] :
                  sres_r[31:0] - {1'b0, cfg.center_distance};
      end
      OP_RX: rx_r <= (rxs > RX_LIMIT) ? RX_LIMIT[RX_W-1:0] : rxs[RX_W-1:0];
      OP_T: begin
        t_r     <= tt[T_W-1:0];
        gzero_r <= tt >= T_LIMIT;
      end
      OP_Y: begin
        n_r <= yy[FRAC_BITS+7:FRAC_BITS];
        x_r <= {yy[FRAC_BITS-1:0], {(30-FRAC_BITS){1'b0}}};
      end
      OP_Z: begin
        z_r <= prod_r[59:30];
        q_r <= Q30_ONE;
      end
      OP_EMUL2: p_r <= prod_r[59:30];
      OP_EUPD:  q_r <= Q30_ONE - qd;
      OP_G: g_r <= (gzero_r || n_r >= 8'd31) ? '0 : (q_r >> n_r);
      OP_U: umag_r <= prod_r[61:30];
      OP_A: a_r <= prod_r[FRAC_BITS+A_W-1:FRAC_BITS];
      OP_WMUL2: wlo_r <= prod_r;
      OP_W: begin
        w_r <= (ws > 68'(W_LIMIT)) ? W_LIMIT : ws[32:0];
        if (!cfg.energy_enable) begin
          energy_r <= '0;
        end else if (e_s[33:31] != 3'b000 && e_s[33:31] != 3'b111) begin
          energy_r <= e_s[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          energy_r <= e_s[31:0];
        end
      end
      OP_FYMUL: num_r[0] <= prod_r + (w_r[32] ? {mag_r[0], 32'd0} : 64'd0);
      OP_FZMUL: num_r[1] <= prod_r + (w_r[32] ? {mag_r[1], 32'd0} : 64'd0);
      OP_FZ:    num_r[2] <= prod_r + (w_r[32] ? {mag_r[2], 32'd0} : 64'd0);
      OP_DIVINIT: begin
        for (int i = 0; i < 3; i++) begin
          ovf_r[i] <= num_r[i][63:32] >= r_r;
          rem_r[i] <= num_r[i][63:32];
          lo_r[i]  <= num_r[i][31:0];
          quo_r[i] <= '0;
        end
      end
      OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if ({rem_r[i], lo_r[i][31]} >= {1'b0, r_r}) begin
            rem_r[i] <= 32'({rem_r[i], lo_r[i][31]} - {1'b0, r_r});
            quo_r[i] <= {quo_r[i][30:0], 1'b1};
          end else begin
            rem_r[i] <= {rem_r[i][30:0], lo_r[i][31]};
            quo_r[i] <= {quo_r[i][30:0], 1'b0};
          end
          lo_r[i] <= {lo_r[i][30:0], 1'b0};
        end
      end
      OP_FIN: begin
        for (int i = 0; i < 3; i++) begin
          if (stat.r_zero) begin
            f_r[i] <= '0;
          end else if (dneg_r[i] != fneg) begin
            f_r[i] <= (ovf_r[i] || quo_r[i][31]) ? 32'sh8000_0000 : -$signed(quo_r[i]);
          end else begin
            f_r[i] <= (ovf_r[i] || quo_r[i][31]) ? 32'sh7FFF_FFFF : $signed(quo_r[i]);
          end
        end
      end
      default: ;
    endcase
  end

  // Running sums with 48-bit saturation; cleared after the last neighbor.
  logic signed [48:0] s49 [3];
  logic signed [47:0] sat48 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s49[i] = 49'(acc_r[i]) + 49'(f_r[i]);
      if (s49[i][48] != s49[i][47]) begin
        sat48[i] = s49[i][48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
        sat48[i] = s49[i][47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end else if (cmd.op == OP_ACC) begin
      for (int i = 0; i < 3; i++) acc_r[i] <= last_r ? 48'sd0 : sat48[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACC) begin
      out_r.pair_fx     <= f_r[0];
      out_r.pair_fy     <= f_r[1];
      out_r.pair_fz     <= f_r[2];
      out_r.pair_energy <= energy_r;
      out_r.in_range    <= hit_r;
      out_r.sum_fx      <= sat48[0];
      out_r.sum_fy      <= sat48[1];
      out_r.sum_fz      <= sat48[2];
      out_r.sum_final   <= last_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/core/gaussian_pair_force.sv =====
// Gaussian cut pair force: per-neighbor force, energy and running force sums.
// A pair inside the cutoff passes the 32-step square root, the 9-term exponential
// series on the shared 32x32 multiplier and the 32-step divider; a pair outside
// it skips them and goes straight to the running sums.
// Items are taken one at a time, and a stalled result beat holds the block.
// Synchronous active-low reset clears the sums and loads register defaults.
module gaussian_pair_force import gpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cut_sq          <= '0;
      cfg_r.center_distance <= '0;
      cfg_r.inv_sigma       <= 31'd1 << FRAC_BITS;
      cfg_r.prefactor       <= '0;
      cfg_r.energy_offset   <= '0;
      cfg_r.energy_enable   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CUT_SQ:    cfg_r.cut_sq          <= cfg_data;
        REG_CENTER:    cfg_r.center_distance <= cfg_data[30:0];
        REG_INV_SIGMA: cfg_r.inv_sigma       <= cfg_data[30:0];
        REG_PREFACTOR: cfg_r.prefactor       <= cfg_data;
        REG_OFFSET:    cfg_r.energy_offset   <= cfg_data;
        REG_ENERGY_EN: cfg_r.energy_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gpf_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/gpf_checker.sv =====
// Port-level checks of the Gaussian pair force block and their binding.
`include "gaussian_pair_force_defines.svh"

module gpf_checker import gpf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A waiting result beat keeps its payload.
  `GPF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // The block works on one item at a time.
  `GPF_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // Pairs beyond the cutoff contribute neither force nor energy.
  `GPF_ASSERT_IMP(a_out_of_range_zero, out_valid && !out_data.in_range,
    out_data.pair_fx == 0 && out_data.pair_fy == 0 && out_data.pair_fz == 0 &&
    out_data.pair_energy == 0)

endmodule

bind gaussian_pair_force gpf_checker u_gpf_checker (.*);

// ===== sim/gaussian_pair_force_checker.sv =====
// Checker for the Gaussian pair force block: predicts each result and compares it.
`timescale 1ns / 1ps

module gaussian_pair_force_checker import gpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending_count
);

  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  cfg_t      regs;
  longint    force_sum_x, force_sum_y, force_sum_z;
  out_item_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // exp(-t) in Q30 via 2^-n times a nine-term series for the fraction.
  function automatic logic [63:0] neg_exp_q30(input logic [63:0] t);
    logic [63:0] y, n, x, z, q;
    if (t >= (64'd64 << FRAC_BITS)) return 0;
    y = (t * 64'd1549082005) >> 30;
    n = y >> FRAC_BITS;
    x = (y & ((64'd1 << FRAC_BITS) - 1)) << (30 - FRAC_BITS);
    z = (x * 64'd744261118) >> 30;
    q = 64'd1 << 30;
    for (int k = 9; k >= 1; k--)
      q = (64'd1 << 30) - ((z * q) >> 30) / k;
    if (n >= 31) return 0;
    return q >> n;
  endfunction

  function automatic longint force_component(input longint d, input logic [63:0] w,
                                             input logic [63:0] r, input bit flip);
    logic [63:0] m;
    if (r == 0) return 0;
    m = ((d < 0 ? -d : d) * w) / r;
    if ((d < 0) != flip) return (m >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(m);
    return (m > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(m);
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sum_add(input longint a, input longint f);
    longint s;
    s = a + f;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  function automatic out_item_t pair_force_predict(input in_item_t item);
    out_item_t    res;
    longint       dx, dy, dz, u, fx, fy, fz, energy, pref;
    logic [63:0]  ax, ay, az, rsq, r, diff, rx, g, umag, a, w, inv;
    logic [127:0] wide;
    bit           hit, rneg, uneg;
    dx = longint'(item.disp_x);
    dy = longint'(item.disp_y);
    dz = longint'(item.disp_z);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    rsq = ax * ax + ay * ay + az * az;
    hit = rsq < ({32'd0, regs.cut_sq} << FRAC_BITS);
    fx = 0; fy = 0; fz = 0; energy = 0;
    if (hit) begin
      inv  = {33'd0, regs.inv_sigma};
      pref = longint'(regs.prefactor);
      r    = int_sqrt(rsq);
      rneg = r < {33'd0, regs.center_distance};
      diff = rneg ? {33'd0, regs.center_distance} - r : r - {33'd0, regs.center_distance};
      rx   = (diff * inv) >> FRAC_BITS;
      if (rx > (64'd16 << FRAC_BITS)) rx = 64'd16 << FRAC_BITS;
      g    = neg_exp_q30((rx * rx) >> (FRAC_BITS + 1));
      uneg = pref < 0;
      umag = ((pref < 0 ? -pref : pref) * g) >> 30;
      u    = uneg ? -longint'(umag) : longint'(umag);
      a    = (rx * umag) >> FRAC_BITS;
      wide = ({64'd0, a} * {64'd0, inv}) >> FRAC_BITS;
      w    = (wide > 128'h1_FFFF_FFFF) ? 64'h1_FFFF_FFFF : wide[63:0];
      fx = force_component(dx, w, r, rneg != uneg);
      fy = force_component(dy, w, r, rneg != uneg);
      fz = force_component(dz, w, r, rneg != uneg);
      if (regs.energy_enable) energy = sat32(u - longint'(regs.energy_offset));
    end
    force_sum_x = sum_add(force_sum_x, fx);
    force_sum_y = sum_add(force_sum_y, fy);
    force_sum_z = sum_add(force_sum_z, fz);
    res.pair_fx     = fx[31:0];
    res.pair_fy     = fy[31:0];
    res.pair_fz     = fz[31:0];
    res.pair_energy = energy[31:0];
    res.in_range    = hit;
    res.sum_fx      = force_sum_x[47:0];
    res.sum_fy      = force_sum_y[47:0];
    res.sum_fz      = force_sum_z[47:0];
    res.sum_final   = item.last_neighbor;
    if (item.last_neighbor) begin
      force_sum_x = 0;
      force_sum_y = 0;
      force_sum_z = 0;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      regs.cut_sq          <= '0;
      regs.center_distance <= '0;
      regs.inv_sigma       <= 31'd1 << FRAC_BITS;
      regs.prefactor       <= '0;
      regs.energy_offset   <= '0;
      regs.energy_enable   <= 1'b1;
      force_sum_x = 0;
      force_sum_y = 0;
      force_sum_z = 0;
      fail_count  = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CUT_SQ:    regs.cut_sq          <= cfg_data;
          REG_CENTER:    regs.center_distance <= cfg_data[30:0];
          REG_INV_SIGMA: regs.inv_sigma       <= cfg_data[30:0];
          REG_PREFACTOR: regs.prefactor       <= cfg_data;
          REG_OFFSET:    regs.energy_offset   <= cfg_data;
          REG_ENERGY_EN: regs.energy_enable   <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(pair_force_predict(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result beat with no expectation waiting, actual %p", $time,
                   out_data);
          fail_count++;
        end else begin
          exp_item = expected_results.pop_front();
          check_field("pair_fx", exp_item.pair_fx, out_data.pair_fx);
          check_field("pair_fy", exp_item.pair_fy, out_data.pair_fy);
          check_field("pair_fz", exp_item.pair_fz, out_data.pair_fz);
          check_field("pair_energy", exp_item.pair_energy, out_data.pair_energy);
          check_field("in_range", exp_item.in_range, out_data.in_range);
          check_field("sum_fx", exp_item.sum_fx, out_data.sum_fx);
          check_field("sum_fy", exp_item.sum_fy, out_data.sum_fy);
          check_field("sum_fz", exp_item.sum_fz, out_data.sum_fz);
          check_field("sum_final", exp_item.sum_final, out_data.sum_final);
        end
      end
    end
  end

endmodule

// ===== sim/gaussian_pair_force_tb.sv =====
// Testbench top for the Gaussian pair force block: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module gaussian_pair_force_tb;
  import gpf_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 150;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  int                   fail_count;
  int                   pending_count;
  int                   idle_cycles = 0;
  int                   stall_left = 0;
  bit                   steady = 1'b0;

  always #2 clk = ~clk;

  gaussian_pair_force i_dut (.*);

  gaussian_pair_force_checker i_checker (.*);

  function automatic int gap_len();
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Result side stalls at random.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      stall_left <= gap_len();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_pair(input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input bit last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{disp_x: x, disp_y: y, disp_z: z, last_neighbor: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setup(input logic [31:0] cut, input logic [31:0] ctr,
                            input logic [31:0] isig, input logic [31:0] pref,
                            input logic [31:0] offs, input bit en);
    write_reg(REG_CUT_SQ, cut);
    write_reg(REG_CENTER, ctr);
    write_reg(REG_INV_SIGMA, isig);
    write_reg(REG_PREFACTOR, pref);
    write_reg(REG_OFFSET, offs);
    write_reg(REG_ENERGY_EN, en);
  endtask

  // Mostly displacements near the cutoff scale, sometimes any 32-bit value.
  function automatic logic [31:0] rand_disp(input int unsigned span);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic random_pairs(input int count, input int unsigned span);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == count / 2) wait_idle();
      send_pair(rand_disp(span), rand_disp(span), rand_disp(span),
                $urandom_range(0, 7) == 0);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setup: cutoff of zero keeps every pair out of range.
    send_pair(32'h0, 32'h0, 32'h0, 1'b0);
    send_pair(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b1);
    wait_idle();

    load_setup(32'd9 << 16, 32'd1 << 16, 32'd2 << 16, 32'h0001_8000, 32'h0000_1000, 1'b1);
    send_pair(32'h0, 32'h0, 32'h0, 1'b0);
    send_pair(32'h0001_0000, 32'h0, 32'h0, 1'b0);
    send_pair(32'h0, 32'hFFFF_8000, 32'h0, 1'b0);
    send_pair(32'h0, 32'h0, 32'h0002_0000, 1'b0);
    send_pair(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    send_pair(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 1'b1);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    wait_idle();

    // Widest settings: huge cutoff, far peak, steep width, saturating force.
    load_setup(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 1'b1);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_pair(32'h0, 32'h0, 32'h0, 1'b0);
    send_pair(32'h0000_0100, 32'h0, 32'h0, 1'b1);
    wait_idle();

    load_setup(32'hFFFF_FFFF, 32'h0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_pair(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);
    send_pair(32'h7FFF_0000, 32'h0, 32'h8000_0000, 1'b1);
    wait_idle();

    // Peak sits at the first pair's distance; the later pairs saturate the x force.
    load_setup(32'hFFFF_FFFF, 32'd2 << 16, 32'd4 << 16, 32'h7FFF_FFFF, 32'h0, 1'b1);
    send_pair(32'h0002_0000, 32'h0, 32'h0, 1'b0);
    for (int i = 0; i < 6; i++)
      send_pair(32'h0002_4000, 32'h0000_4000, 32'hFFFF_C000, i == 5);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      load_setup($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1 << 16, 64 << 16),
                 $urandom_range(0, 3) == 0 ? $urandom >> 1 : $urandom_range(0, 4 << 16),
                 $urandom_range(0, 3) == 0 ? ($urandom >> 1) | 1 : $urandom_range(1, 8 << 16),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8 << 16) - (4 << 16),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 16) - (1 << 15),
                 $urandom_range(0, 3) != 0);
      random_pairs(200, 32'd6 << 16);
      wait_idle();
    end

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
